// ===== rtl/vnf_pkg.sv =====
// Shared types, constants and the shaping-curve table for the value noise height block.
// Depends on nothing; every other file of the block but vnf_ram imports it.
package vnf_pkg;

  localparam int MAX_OCTAVES      = 8;
  localparam int GRID_BITS        = 12;
  localparam int CURVE_TABLE_BITS = 10;

  localparam int CURVE_N   = 1 << CURVE_TABLE_BITS;
  localparam int CURVE_AW  = $clog2(CURVE_N + 1);
  localparam int CNT_W     = $clog2(MAX_OCTAVES + 1);
  localparam int KIDX_W    = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int POS_W     = 56;
  localparam int SUM_W     = 24 + MAX_OCTAVES;
  localparam int A8_W      = SUM_W - 8;
  localparam int RECIP_SH  = 16 + 2 * MAX_OCTAVES;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int CELL_DEPTH = 5;
  localparam int LATENCY   = 1 + CELL_DEPTH * MAX_OCTAVES + 3;

  localparam logic [31:0] HASH_X    = 32'd374761393;
  localparam logic [31:0] HASH_Y    = 32'd668265263;
  localparam logic [31:0] HASH_S    = 32'd2246822519;
  localparam logic [31:0] HASH_MIX  = 32'd1274126177;
  localparam logic [31:0] SEED_STEP = 32'd101;

  localparam logic [7:0] REG_SEED     = 8'd0;
  localparam logic [7:0] REG_OCTAVES  = 8'd1;
  localparam logic [7:0] REG_STEP     = 8'd2;
  localparam logic [7:0] REG_MAX_HGT  = 8'd3;

  typedef struct packed {
    logic [GRID_BITS-1:0] grid_x;
    logic [GRID_BITS-1:0] grid_y;
  } item_t;

  typedef struct packed {
    logic [15:0] height;
    logic [15:0] elevation;
  } result_t;

  // Word handed from one octave cell to the next.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [31:0]      seed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [SUM_W-1:0] acc;
  } token_t;

  typedef logic [15:0] curve_rom_t [CURVE_N+1];

  // Shaping curve x^1.6 scaled to Q0.16, found by a bitwise fifth-root search.
  function automatic curve_rom_t build_curve();
    curve_rom_t   rom;
    logic [127:0] c;
    logic [127:0] p;
    logic [127:0] r;
    logic [127:0] cand;
    logic [127:0] y;
    int           i;
    int           b;
    for (i = 0; i <= CURVE_N; i++) begin
      c = 128'(i) * 128'(i) * 128'(i);
      p = (c << 32) >> (3 * CURVE_TABLE_BITS);
      r = '0;
      for (b = 15; b >= 0; b--) begin
        cand = r | (128'd1 << b);
        if (cand * cand * cand * cand * cand <= (p << 48)) r = cand;
      end
      y = (128'(i) * r) >> CURVE_TABLE_BITS;
      rom[i] = (y > 128'd65535) ? 16'hFFFF : y[15:0];
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

endpackage

// ===== rtl/vnf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module vnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/vnf_cell.sv =====
// One octave cell: hashes the four lattice corners, blends them and folds the
// octave into the running sum over five register stages. Uses vnf_pkg.
module vnf_cell
  import vnf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  token_t in_tok,
  output logic   out_valid,
  output token_t out_tok
);

  // Stage A: hash products and squared fractions.
  logic        va, act_a;
  token_t      tok_a;
  logic [31:0] mx0, mx1, my0, my1, ms;
  logic [15:0] tx, ty;
  logic [31:0] ttx, tty;
  // Stage B: mixed hashes and smoothstep weights.
  logic        vb, act_b;
  token_t      tok_b;
  logic [31:0] m00, m10, m01, m11;
  logic [16:0] wx, wy;
  // Stage C: blend along x.
  logic        vc, act_c;
  token_t      tok_c;
  logic [23:0] la, lb;
  logic [16:0] wy_c;
  // Stage D: blend along y.
  logic        vd, act_d;
  token_t      tok_d;
  logic [23:0] nval;

  logic [31:0] x0, y0, x1, y1;
  logic [31:0] h00, h10, h01, h11;
  logic [49:0] sx, sy;
  logic [23:0] v00, v10, v01, v11;
  logic [41:0] la_s, lb_s, n_s;

  function automatic logic [31:0] pre_mix(input logic [31:0] h);
    return h ^ (h >> 13);
  endfunction

  function automatic logic [23:0] fin_mix(input logic [31:0] m);
    logic [31:0] f;
    f = m ^ (m >> 16);
    return f[23:0];
  endfunction

  always_comb begin
    x0 = in_tok.pos_x[55:24];
    y0 = in_tok.pos_y[55:24];
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    h00 = mx0 + my0 + ms;
    h10 = mx1 + my0 + ms;
    h01 = mx0 + my1 + ms;
    h11 = mx1 + my1 + ms;
    sx = 50'(ttx) * 50'(18'd196608 - 18'({tx, 1'b0}));
    sy = 50'(tty) * 50'(18'd196608 - 18'({ty, 1'b0}));
    v00 = fin_mix(m00);
    v10 = fin_mix(m10);
    v01 = fin_mix(m01);
    v11 = fin_mix(m11);
    la_s = 42'(v00) * 42'(17'd65536 - wx) + 42'(v10) * 42'(wx);
    lb_s = 42'(v01) * 42'(17'd65536 - wx) + 42'(v11) * 42'(wx);
    n_s  = 42'(la) * 42'(17'd65536 - wy_c) + 42'(lb) * 42'(wy_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    act_a <= (in_tok.cnt != '0);
    tok_a <= in_tok;
    mx0 <= x0 * HASH_X;
    mx1 <= x1 * HASH_X;
    my0 <= y0 * HASH_Y;
    my1 <= y1 * HASH_Y;
    ms  <= in_tok.seed * HASH_S;
    tx  <= in_tok.pos_x[23:8];
    ty  <= in_tok.pos_y[23:8];
    ttx <= 32'(in_tok.pos_x[23:8]) * 32'(in_tok.pos_x[23:8]);
    tty <= 32'(in_tok.pos_y[23:8]) * 32'(in_tok.pos_y[23:8]);

    act_b <= act_a;
    tok_b <= tok_a;
    m00 <= pre_mix(h00) * HASH_MIX;
    m10 <= pre_mix(h10) * HASH_MIX;
    m01 <= pre_mix(h01) * HASH_MIX;
    m11 <= pre_mix(h11) * HASH_MIX;
    wx  <= sx[48:32];
    wy  <= sy[48:32];

    act_c <= act_b;
    tok_c <= tok_b;
    la    <= la_s[39:16];
    lb    <= lb_s[39:16];
    wy_c  <= wy;

    act_d <= act_c;
    tok_d <= tok_c;
    nval  <= n_s[39:16];

    // Inactive cells pass the word on untouched once the octave count is used up.
    out_tok <= tok_d;
    if (act_d) begin
      out_tok.acc   <= SUM_W'({tok_d.acc, 1'b0}) + SUM_W'(nval);
      out_tok.cnt   <= tok_d.cnt - CNT_W'(1);
      out_tok.seed  <= tok_d.seed + SEED_STEP;
      out_tok.pos_x <= {tok_d.pos_x[POS_W-2:0], 1'b0};
      out_tok.pos_y <= {tok_d.pos_y[POS_W-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/vnf_shape.sv =====
// Normalizes the octave sum, looks up the shaping curve and scales by max_height.
// Holds the curve RAM and its fill after reset. Uses vnf_pkg and vnf_ram.
module vnf_shape
  import vnf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] acc,
  input  logic [CNT_W-1:0] k_eff,
  input  logic [15:0]      max_height,
  output logic             busy,
  output logic             done,
  output result_t          result
);

  localparam int P_W = A8_W + RECIP_W;

  logic [RECIP_W-1:0] recip [MAX_OCTAVES];

  // Reciprocal of 2^k - 1, rounded up; exact floor for every sum the cells produce.
  for (genvar k = 1; k <= MAX_OCTAVES; k++) begin : g_recip
    localparam logic [RECIP_W-1:0] RK = RECIP_W'(((64'd1 << RECIP_SH) + (64'd1 << k) - 64'd2)
                                                 / ((64'd1 << k) - 64'd1));
    assign recip[k-1] = RK;
  end

  logic                filling;
  logic [CURVE_AW-1:0] fill_addr;
  logic                v0, v1;
  logic [P_W-1:0]      prod;
  logic [15:0]         e_now, e1;
  logic [16:0]         e_rnd;
  logic [CURVE_AW-1:0] idx_raw, idx;
  logic [15:0]         curve_q;
  logic [32:0]         h_s;
  logic [KIDX_W-1:0]   kidx;

  assign busy = filling;
  assign kidx = KIDX_W'(k_eff - CNT_W'(1));

  always_comb begin
    if (prod[P_W-1:RECIP_SH] > (P_W - RECIP_SH)'(16'hFFFF)) e_now = 16'hFFFF;
    else e_now = prod[RECIP_SH+15:RECIP_SH];
    e_rnd   = {1'b0, e_now} + 17'(1 << (15 - CURVE_TABLE_BITS));
    idx_raw = CURVE_AW'(e_rnd >> (16 - CURVE_TABLE_BITS));
    idx     = (idx_raw > CURVE_AW'(CURVE_N)) ? CURVE_AW'(CURVE_N) : idx_raw;
    h_s     = 33'(curve_q) * 33'(max_height) + 33'd32768;
  end

  vnf_ram #(
    .WIDTH(16),
    .DEPTH(CURVE_N + 1)
  ) u_curve (
    .clk  (clk),
    .we   (filling),
    .waddr(fill_addr),
    .wdata(CURVE_ROM[fill_addr]),
    .re   (v0),
    .raddr(idx),
    .rdata(curve_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (filling) begin
        fill_addr <= fill_addr + CURVE_AW'(1);
        if (fill_addr == CURVE_AW'(CURVE_N)) filling <= 1'b0;
      end
      v0   <= in_valid;
      v1   <= v0;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= P_W'(acc[SUM_W-1:8]) * P_W'(recip[kidx]);
    e1   <= e_now;
    result.elevation <= e1;
    result.height    <= h_s[32] ? 16'hFFFF : h_s[31:16];
  end

endmodule

// ===== rtl/value_noise_fbm_height.sv =====
// Top level of the fractal value noise height block: registers, input stage,
// the row of octave cells and the shaping stage. Uses vnf_pkg, vnf_cell, vnf_shape.
//
// Usage: a grid point is taken on item when start is high and busy is low.
// Exactly one result word appears on result with done high for one cycle,
// after the accepting edge has passed it through one input stage, five stages
// in each of the eight octave cells, and three stages of normalize, curve
// read and height multiply. While busy is low, a new grid point can be taken every cycle, since
// each octave cell is a pipeline of its own and the word moves one stage per cycle.
// Octaves beyond the clamped octave count (zero acts as one) pass through their cell unchanged.
// After reset, busy stays high while the curve RAM is filled,
// one entry per cycle; configuration writes are taken during that time.
// The configuration channel is always ready; register writes must be made
// while no result is pending. The receiver cannot stall: done is a strobe.
module value_noise_fbm_height
  import vnf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] seed;
  logic [3:0]  octave_count;
  logic [31:0] step_per_cell;
  logic [15:0] max_height;

  logic [CNT_W-1:0] k_eff;
  logic             accept;
  logic             vld [MAX_OCTAVES+1];
  token_t           tok [MAX_OCTAVES+1];

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (octave_count == 4'd0) k_eff = CNT_W'(1);
    else if (32'(octave_count) > MAX_OCTAVES) k_eff = CNT_W'(MAX_OCTAVES);
    else k_eff = CNT_W'(octave_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed          <= 32'd0;
      octave_count  <= 4'd4;
      step_per_cell <= 32'd262144;
      max_height    <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEED:    seed          <= cfg_data;
        REG_OCTAVES: octave_count  <= cfg_data[3:0];
        REG_STEP:    step_per_cell <= cfg_data;
        REG_MAX_HGT: max_height    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= accept;
  end

  always_ff @(posedge clk) begin
    tok[0].cnt   <= k_eff;
    tok[0].seed  <= seed;
    tok[0].pos_x <= POS_W'(item.grid_x) * POS_W'(step_per_cell);
    tok[0].pos_y <= POS_W'(item.grid_y) * POS_W'(step_per_cell);
    tok[0].acc   <= '0;
  end

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_cell
    vnf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld[o]),
      .in_tok   (tok[o]),
      .out_valid(vld[o+1]),
      .out_tok  (tok[o+1])
    );
  end

  vnf_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[MAX_OCTAVES]),
    .acc       (tok[MAX_OCTAVES].acc),
    .k_eff     (k_eff),
    .max_height(max_height),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== rtl/vnf_checker.sv =====
// Port-level checks for value_noise_fbm_height, attached by the bind below.
// Uses vnf_pkg for the fixed latency.
module vnf_checker
  import vnf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result word always traces back to a grid point taken a fixed time earlier.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result word without a matching grid point");

  a_fill_after_reset: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("curve fill did not start after reset");

  a_busy_only_from_reset: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(rst))
    else $error("busy rose outside reset");

  a_no_result_while_filling: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result word during curve fill");

endmodule

bind value_noise_fbm_height vnf_checker u_vnf_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

// ===== tb/tb.sv =====
// Testbench for value_noise_fbm_height: drives grid points, predicts height and
// elevation with its own fixed-point noise model, and checks every result word.
// Depends on vnf_pkg and the value_noise_fbm_height RTL.
module tb;
  import vnf_pkg::*;

  // Index that no register answers to; the write must be ignored.
  localparam logic [7:0] REG_UNUSED = 8'd200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  value_noise_fbm_height dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers.
  logic [31:0] p_seed;
  logic [3:0]  p_octaves;
  logic [31:0] p_step;
  logic [15:0] p_max_hgt;
  logic [15:0] shape_lut [CURVE_N+1];

  item_t   grid_queue[$];
  result_t height_queue[$];
  int      mismatches;
  logic    idle_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [15:0] fifth_root_curve(int i);
    logic [127:0] c;
    logic [127:0] p;
    logic [127:0] r;
    logic [127:0] cand;
    logic [127:0] y;
    c = 128'(i) * 128'(i) * 128'(i);
    p = (c << 32) >> (3 * CURVE_TABLE_BITS);
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand * cand * cand * cand <= (p << 48)) r = cand;
    end
    y = (128'(i) * r) >> CURVE_TABLE_BITS;
    return (y > 128'd65535) ? 16'hFFFF : y[15:0];
  endfunction

  function automatic logic [23:0] lattice_hash(logic [31:0] x, logic [31:0] y, logic [31:0] s);
    logic [31:0] h;
    h = x * HASH_X + y * HASH_Y + s * HASH_S;
    h = (h ^ (h >> 13)) * HASH_MIX;
    h = h ^ (h >> 16);
    return h[23:0];
  endfunction

  function automatic logic [63:0] smooth_w(logic [63:0] t);
    logic [63:0] v;
    v = t * t * (64'd196608 - 64'd2 * t);
    return v >> 32;
  endfunction

  function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  function automatic logic [63:0] octave_noise(logic [11:0] gx, logic [11:0] gy, int o);
    logic [63:0] px;
    logic [63:0] py;
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] s;
    logic [63:0] wx;
    logic [63:0] wy;
    logic [63:0] a;
    logic [63:0] b;
    px = (64'(gx) * 64'(p_step)) << o;
    py = (64'(gy) * 64'(p_step)) << o;
    x0 = px[55:24];
    y0 = py[55:24];
    wx = smooth_w(64'(px[23:8]));
    wy = smooth_w(64'(py[23:8]));
    s = p_seed + SEED_STEP * 32'(o);
    a = blend(64'(lattice_hash(x0, y0, s)), 64'(lattice_hash(x0 + 32'd1, y0, s)), wx);
    b = blend(64'(lattice_hash(x0, y0 + 32'd1, s)),
              64'(lattice_hash(x0 + 32'd1, y0 + 32'd1, s)), wx);
    return blend(a, b, wy);
  endfunction

  function automatic result_t predict_height(item_t g);
    int          k;
    logic [63:0] sum;
    logic [63:0] d;
    logic [63:0] e;
    logic [63:0] idx;
    logic [63:0] h;
    result_t     r;
    k = int'(p_octaves);
    if (k < 1) k = 1;
    if (k > MAX_OCTAVES) k = MAX_OCTAVES;
    sum = 0;
    for (int o = 0; o < k; o++)
      sum += octave_noise(g.grid_x, g.grid_y, o) << (MAX_OCTAVES - 1 - o);
    d = (64'd1 << MAX_OCTAVES) - (64'd1 << (MAX_OCTAVES - k));
    e = sum / (d << 8);
    if (e > 65535) e = 65535;
    idx = (e + (64'd1 << (15 - CURVE_TABLE_BITS))) >> (16 - CURVE_TABLE_BITS);
    if (idx > CURVE_N) idx = CURVE_N;
    h = (64'(shape_lut[idx]) * 64'(p_max_hgt) + 64'd32768) >> 16;
    if (h > 65535) h = 65535;
    r.height = h[15:0];
    r.elevation = e[15:0];
    return r;
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    #1;
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SEED:    p_seed = val;
      REG_OCTAVES: p_octaves = val[3:0];
      REG_STEP:    p_step = val;
      REG_MAX_HGT: p_max_hgt = val[15:0];
      default: ;
    endcase
  endtask

  // Lets the pipeline drain before registers change.
  task automatic drain();
    while (grid_queue.size() != 0 || height_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic push_grid(logic [11:0] x, logic [11:0] y);
    item_t g;
    g.grid_x = x;
    g.grid_y = y;
    grid_queue.insert(grid_queue.size(), g);
  endtask

  // Driver: one word per accepting edge, random gap bursts between words.
  int gap;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else if (!(start && busy)) begin
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (grid_queue.size() != 0) begin
        start <= 1'b1;
        item  <= grid_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance and prediction at the rising edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      height_queue.insert(height_queue.size(), predict_height(grid_queue.pop_front()));
      if (!idle_off && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (height_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result word with nothing expected: %h", result);
      end else begin
        want = height_queue.pop_front();
        if (result.height !== want.height || result.elevation !== want.elevation) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch height exp %h got %h, elevation exp %h got %h",
                     want.height, result.height, want.elevation, result.elevation);
        end
      end
    end
  end

  logic [31:0] seeds [4] = '{32'd0, 32'hFFFFFFFF, 32'h12345678, 32'h80000001};
  logic [31:0] steps [5] = '{32'd262144, 32'd0, 32'hFFFFFFFF, 32'h01000000, 32'h00001234};

  initial begin
    int n;
    for (int i = 0; i <= CURVE_N; i++) shape_lut[i] = fifth_root_curve(i);
    p_seed = 0; p_octaves = 4; p_step = 262144; p_max_hgt = 256;
    mismatches = 0;
    idle_off = 1'b0;
    rst = 1'b1; start = 1'b0; item = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes under reset settings, then each register extreme.
    push_grid(12'd0, 12'd0);
    push_grid(12'hFFF, 12'hFFF);
    push_grid(12'hFFF, 12'd0);
    push_grid(12'd0, 12'hFFF);
    push_grid(12'hAAA, 12'h555);
    push_grid(12'h555, 12'hAAA);
    drain();
    // Octave count zero acts as one, above the maximum acts as the maximum.
    foreach (seeds[i]) begin
      write_reg(REG_SEED, seeds[i]);
      write_reg(REG_OCTAVES, (i == 0) ? 32'd0 : (i == 1) ? 32'd15 : (i == 2) ? 32'd1 : 32'd8);
      write_reg(REG_STEP, steps[i + 1]);
      write_reg(REG_MAX_HGT, (i % 2) ? 32'hFFFF : 32'd0);
      write_reg(REG_UNUSED, 32'hDEADBEEF);
      push_grid(12'd0, 12'd0);
      push_grid(12'hFFF, 12'hFFF);
      push_grid(12'($urandom), 12'($urandom));
      push_grid(12'd1, 12'hFFE);
      drain();
    end

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_SEED, $urandom);
      write_reg(REG_OCTAVES, $urandom_range(0, 15));
      n = $urandom_range(0, 3);
      write_reg(REG_STEP, (n == 0) ? $urandom : (n == 1) ? steps[$urandom_range(0, 4)]
                          : 32'($urandom_range(0, 32'h00400000)));
      write_reg(REG_MAX_HGT, ($urandom_range(0, 4) == 0) ? 32'hFFFF : $urandom_range(0, 65535));
      if (ph == 10) idle_off = 1'b1;
      for (int j = 0; j < 150; j++) push_grid(12'($urandom), 12'($urandom));
      drain();
    end

    if (mismatches == 0 && height_queue.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
